### design/pmpd_pkg.sv
// shared types and constants for the ps/2 mouse packet decoder
package pmpd_pkg;

  localparam int BUTTON_COUNT = 3;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int PACKET_LAST_POS = 2;

  typedef enum logic [1:0] {
    KIND_MOVE = 2'd0,
    KIND_DOWN = 2'd1,
    KIND_UP   = 2'd2
  } pmpd_kind_t;

  // one completed packet that has at least one event to report
  typedef struct packed {
    logic                    move;
    logic [7:0]              dx;
    logic [7:0]              dy;
    logic [BUTTON_COUNT-1:0] change;
    logic [BUTTON_COUNT-1:0] prev;
  } pmpd_job_t;

endpackage

### design/pmpd_front.sv
// front end: byte assembly, packet classification and button tracking
module pmpd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              aux_ready,
  input  logic [7:0]        data_byte,
  input  logic              q_full,
  output logic              q_push,
  output pmpd_pkg::pmpd_job_t q_job
);
  import pmpd_pkg::*;

  logic                    events_enable;
  logic [1:0]              byte_position;
  logic [7:0]              byte0;
  logic [7:0]              byte1;
  logic [BUTTON_COUNT-1:0] prev_buttons;
  logic                    accept;
  logic                    completes;
  pmpd_job_t               job;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready && aux_ready;
  assign completes = accept && (byte_position == 2'(PACKET_LAST_POS)) && events_enable;

  always_comb begin
    job.move   = (byte1 != 8'd0) || (data_byte != 8'd0);
    job.dx     = byte1;
    job.dy     = 8'(8'd0 - data_byte);
    job.change = byte0[BUTTON_COUNT-1:0] ^ prev_buttons;
    job.prev   = prev_buttons;
  end

  assign q_job  = job;
  assign q_push = completes && (job.move || (job.change != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      events_enable <= 1'b1;
      byte_position <= 2'd0;
      prev_buttons  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        events_enable <= cfg_data;
      end
      if (accept) begin
        if (byte_position == 2'(PACKET_LAST_POS)) begin
          byte_position <= 2'd0;
        end else begin
          byte_position <= byte_position + 2'd1;
        end
      end
      if (completes) begin
        prev_buttons <= byte0[BUTTON_COUNT-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (byte_position == 2'd0)) begin
      byte0 <= data_byte;
    end
    if (accept && (byte_position == 2'd1)) begin
      byte1 <= data_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position != 2'd3)
    else $error("byte position out of range");

  a_push_needs_packet_end: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (byte_position == 2'(PACKET_LAST_POS)) && events_enable)
    else $error("job pushed outside packet end");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

endmodule

### design/pmpd_fifo.sv
// short job queue between front end and event sequencer
module pmpd_fifo #(
  parameter int Depth = pmpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pmpd_pkg::pmpd_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output pmpd_pkg::pmpd_job_t head_job
);
  import pmpd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  pmpd_job_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CntW'(1))
    else $error("queue count did not grow on push");

endmodule

### design/pmpd_back.sv
// event sequencer: expands one job into move and button events
module pmpd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  pmpd_pkg::pmpd_job_t head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          event_kind,
  output logic signed [7:0]   move_x,
  output logic signed [7:0]   move_y,
  output logic [1:0]          button_number,
  output logic                last
);
  import pmpd_pkg::*;

  logic       active;
  pmpd_job_t  work;
  pmpd_job_t  cur;
  pmpd_job_t  rem;
  logic       src_valid;
  logic       load;
  logic       rem_empty;
  pmpd_kind_t ev_kind;
  logic [7:0] ev_x;
  logic [7:0] ev_y;
  logic [1:0] ev_btn;
  logic [1:0] sel;

  assign src_valid = active || head_valid;
  assign cur       = active ? work : head_job;
  assign load      = src_valid && (!out_valid || out_ready);
  assign pop       = load && !active;

  always_comb begin
    sel = 2'd0;
    for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
      if (cur.change[i]) begin
        sel = 2'(i);
      end
    end
  end

  always_comb begin
    rem = cur;
    if (cur.move) begin
      ev_kind  = KIND_MOVE;
      ev_x     = cur.dx;
      ev_y     = cur.dy;
      ev_btn   = 2'd0;
      rem.move = 1'b0;
    end else begin
      ev_kind         = cur.prev[sel] ? KIND_UP : KIND_DOWN;
      ev_x            = 8'd0;
      ev_y            = 8'd0;
      ev_btn          = sel + 2'd1;
      rem.change[sel] = 1'b0;
    end
    rem_empty = !rem.move && (rem.change == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active    <= !rem_empty;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work          <= rem;
      event_kind    <= ev_kind;
      move_x        <= ev_x;
      move_y        <= ev_y;
      button_number <= ev_btn;
      last          <= rem_empty;
    end
  end

  a_move_no_button: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == KIND_MOVE) |-> button_number == 2'd0)
    else $error("move event carries a button number");

  a_button_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != KIND_MOVE) |->
      (button_number != 2'd0) && (move_x == 8'sd0) && (move_y == 8'sd0))
    else $error("button event fields malformed");

  a_active_not_last: assert property (@(posedge clk) disable iff (rst)
    $past(load) && active |-> !last)
    else $error("last flagged while job still has events");

endmodule

### design/ps2_mouse_packet_decoder_unit.sv
// top level of the ps/2 mouse three-byte packet decoder
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   cfg     | cfg_valid, cfg_ready, cfg_data (events_enable)  | in
//   in      | in_valid, in_ready, aux_ready, data_byte        | in
//   out     | out_valid, out_ready, event_kind, move_x,       | out
//           | move_y, button_number, last                     |
//
// the front end takes one input transaction per cycle while the job queue has room
// a completed packet with k events (0 to 4) occupies the sequencer until all are sent,
//   one event per cycle out of the output register, so the output side sets the rate
// reads without aux_ready, the first two bytes of a packet and silent packets
//   never reach the queue
// synchronous active-high reset: events enabled, byte position and buttons cleared
// a stalled output holds the sequencer; input stalls only when the queue is full
module ps2_mouse_packet_decoder_unit #(
  parameter int QueueDepth = pmpd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              aux_ready,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        event_kind,
  output logic signed [7:0] move_x,
  output logic signed [7:0] move_y,
  output logic [1:0]        button_number,
  output logic              last
);
  import pmpd_pkg::*;

  // front to queue
  logic      q_full;
  logic      q_push;
  pmpd_job_t q_job;

  // queue to sequencer
  logic      q_pop;
  logic      head_valid;
  pmpd_job_t head_job;

  // byte assembly, config register and change detection
  pmpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .aux_ready (aux_ready),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // decouples packet arrival from event delivery
  pmpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // move first, then button changes from bit 0 upward
  pmpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .move_x        (move_x),
    .move_y        (move_y),
    .button_number (button_number),
    .last          (last)
  );

endmodule

### test/ps2_mouse_packet_decoder_unit_tb.sv
// testbench for the ps/2 mouse packet decoder: directed and random packets against a local model
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_unit_tb;
  import pmpd_pkg::*;

  localparam int DRAIN_CYCLES = 20;      // output register plus queue, with margin
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run
  localparam int REPORT_MAX   = 10;

  // one expected mouse event as it should leave the output channel
  typedef struct {
    pmpd_kind_t        kind;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic [1:0]        button;
    logic              last;
  } mouse_event_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              aux_ready = 1'b0;
  logic [7:0]        data_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        event_kind;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic [1:0]        button_number;
  logic              last;

  // decoder model state
  logic       model_enable = 1'b1;
  logic [1:0] model_pos = 2'd0;
  logic [7:0] model_pkt [2];
  logic [2:0] model_buttons = 3'd0;

  mouse_event_t pending_events [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 21;
  int recv_idle_pct = 81;

  ps2_mouse_packet_decoder_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .aux_ready    (aux_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .move_x       (move_x),
    .move_y       (move_y),
    .button_number(button_number),
    .last         (last)
  );

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // model one accepted controller read and queue the events it should produce
  function automatic void model_byte(input logic aux, input logic [7:0] b);
    mouse_event_t ev;
    mouse_event_t evs [$];
    if (!aux) return;  // no aux byte present: read is dropped
    if (model_pos < PACKET_LAST_POS) begin
      model_pkt[model_pos[0]] = b;
      model_pos = model_pos + 2'd1;
      return;
    end
    // third byte closes the packet
    model_pos = 2'd0;
    if (!model_enable) return;  // counted but silent, buttons untouched
    if (model_pkt[1] != 8'h00 || b != 8'h00) begin
      ev.kind   = KIND_MOVE;
      ev.dx     = model_pkt[1];
      ev.dy     = ~b + 8'd1;  // negated y, -128 wraps onto itself
      ev.button = 2'd0;
      ev.last   = 1'b0;
      evs.push_back(ev);
    end
    // button 1 first, upper bits of byte 0 play no part
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (model_pkt[0][i] != model_buttons[i]) begin
        ev.kind   = model_buttons[i] ? KIND_UP : KIND_DOWN;
        ev.dx     = 8'sd0;
        ev.dy     = 8'sd0;
        ev.button = 2'(i + 1);
        ev.last   = 1'b0;
        evs.push_back(ev);
      end
    end
    model_buttons = model_pkt[0][2:0];
    if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endfunction

  // compare one output transaction with the oldest pending event
  function automatic void check_event();
    mouse_event_t exp_ev;
    if (pending_events.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("unexpected event: kind %0d x %0d y %0d button %0d last %0b",
                 event_kind, move_x, move_y, button_number, last);
      return;
    end
    exp_ev = pending_events.pop_front();
    if (event_kind !== exp_ev.kind || move_x !== exp_ev.dx || move_y !== exp_ev.dy ||
        button_number !== exp_ev.button || last !== exp_ev.last) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("event mismatch: expected kind %0d x %0d y %0d button %0d last %0b, %s",
                 exp_ev.kind, exp_ev.dx, exp_ev.dy, exp_ev.button, exp_ev.last,
                 $sformatf("got kind %0d x %0d y %0d button %0d last %0b",
                           event_kind, move_x, move_y, button_number, last));
    end
  endfunction

  // output check before input prediction: an event never leaves in the cycle
  // its completing byte is taken
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_event();
      if (in_valid && in_ready) model_byte(aux_ready, data_byte);
    end
  end

  // present one controller read, with a random gap in front, and wait for its transaction
  task automatic send_read(input logic aux, input logic [7:0] b);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    aux_ready <= aux;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_packet(input logic [7:0] b0, input logic [7:0] dx,
                             input logic [7:0] raw_y);
    send_read(1'b1, b0);
    send_read(1'b1, dx);
    send_read(1'b1, raw_y);
  endtask

  // stop sending and let every queued event come out, then the tail of a silent packet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register writes happen only with the decoder idle
  task automatic write_events_enable(input logic en);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    model_enable = en;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // field extremes, every event kind, the four-event packet and silent packets
  task automatic test_directed();
    send_read(1'b0, 8'hFF);                   // no aux flag: ignored
    send_packet(8'h01, 8'h7F, 8'h80);         // max x, y of -128 wraps, button 1 down
    send_read(1'b1, 8'hF8);                   // upper bits set, button 1 released
    send_read(1'b0, 8'h55);                   // dropped read inside a packet
    send_read(1'b1, 8'h80);
    send_read(1'b1, 8'h01);
    send_packet(8'h07, 8'h00, 8'h00);         // buttons only, no move
    send_packet(8'h00, 8'hFF, 8'hFF);         // move plus three releases
    send_packet(8'h00, 8'h00, 8'h00);         // nothing changed: no events
    send_packet(8'h05, 8'h01, 8'h00);         // move with zero y, buttons 1 and 3 down
  endtask

  // events off: packet is counted silently and button state held
  task automatic test_events_disabled();
    write_events_enable(1'b0);
    send_packet(8'h02, 8'h10, 8'hF0);
    send_packet(8'h07, 8'h00, 8'h00);
    write_events_enable(1'b1);
    send_packet(8'h02, 8'h00, 8'h00);         // compares against buttons from before
  endtask

  // random reads, mostly aux bytes so packets keep completing
  task automatic test_random(input int aux_bytes, input int send_pct, input int recv_pct);
    int         n;
    logic       aux;
    logic [7:0] b;
    n = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (n < aux_bytes) begin
      aux = ($urandom_range(99) < 85);
      case ($urandom_range(3))
        0: b = 8'h00;
        1: b = 8'($urandom_range(7));
        default: b = 8'($urandom);
      endcase
      send_read(aux, b);
      if (aux) n++;
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_events_disabled();
    test_random(30, 21, 81);
    write_events_enable(1'b0);
    test_random(12, 81, 21);
    write_events_enable(1'b1);
    test_random(18, 81, 21);
    drain();
    test_random(24, 0, 0);
    drain();

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### ps2_mouse_packet_decoder_unit.f
design/pmpd_pkg.sv
design/pmpd_front.sv
design/pmpd_fifo.sv
design/pmpd_back.sv
design/ps2_mouse_packet_decoder_unit.sv
test/ps2_mouse_packet_decoder_unit_tb.sv
